[hw/rtl/lget_pkg.sv]
`default_nettype none

package lget_pkg;

  // Pixel and result field widths
  localparam int unsigned PIX_W = 8;
  localparam int unsigned COL_W = 10;
  localparam int unsigned ROW_W = 12;

  // Configuration register widths
  localparam int unsigned IMG_W_W   = 11;
  localparam int unsigned IMG_H_W   = 13;
  localparam int unsigned LAP_THR_W = 8;
  localparam int unsigned GRD_THR_W = 17;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // Reset values
  localparam logic [IMG_W_W-1:0]   IMG_W_RST   = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0]   IMG_H_RST   = IMG_H_W'(480);
  localparam logic [LAP_THR_W-1:0] LAP_THR_RST = LAP_THR_W'(165);
  localparam logic [GRD_THR_W-1:0] GRD_THR_RST = GRD_THR_W'(16900);

  // Size limits
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MIN_SIZE      = 3;
  localparam int unsigned HEIGHT_LIMIT  = 4096;

  // Result queue
  localparam int unsigned OQ_DEPTH = 4;

  // Stream data widths (whole bytes)
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_WIDTH  = 2'd0,
    CFG_IMG_HEIGHT = 2'd1,
    CFG_LAP_THR    = 2'd2,
    CFG_GRD_THR    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             last;
    logic             white;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/laplacian_gradient_edge_threshold_top.sv]
// An accepted pixel's result passes the stage 1 and stage 2 registers and is then
//   written into the result queue, which drives m_axis.
// Throughput: one pixel per cycle while the queue has room; the line-buffer RMW (read
//   at accept, write back the next cycle, same-address forwarding) sets this rate.
// Backpressure is absorbed by a 4-entry result queue; s_axis_tready drops once
//   queued plus in-flight requests would fill it.
// Reset clears counters, window, pipeline valids and queue, loads the config registers
//   with their reset values; line buffers are not cleared and take no clearing pass.
`default_nettype none

module laplacian_gradient_edge_threshold_top
  import lget_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel input
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] red_value
  input  wire logic                  s_axis_tuser,  // frame_start
  // classified pixel output
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,  // [9:0] out_col, [21:10] out_row,
                                                    // [22] is_white, [23] zero
  output logic                       m_axis_tlast   // last_pixel
);

  // Column counter / line buffer address width; CW1 also holds the width itself.
  localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned OQ_AW = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW = OQ_AW + 1;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [IMG_W_W-1:0]   img_w_q;
  logic [IMG_H_W-1:0]   img_h_q;
  logic [LAP_THR_W-1:0] lap_thr_q;
  logic [GRD_THR_W-1:0] grd_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= IMG_W_RST;
      img_h_q   <= IMG_H_RST;
      lap_thr_q <= LAP_THR_RST;
      grd_thr_q <= GRD_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMG_WIDTH:  img_w_q   <= cfg_data_i[IMG_W_W-1:0];
        CFG_IMG_HEIGHT: img_h_q   <= cfg_data_i[IMG_H_W-1:0];
        CFG_LAP_THR:    lap_thr_q <= cfg_data_i[LAP_THR_W-1:0];
        CFG_GRD_THR:    grd_thr_q <= cfg_data_i[GRD_THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the supported range
  logic [CW1-1:0]     w_eff;
  logic [IMG_H_W-1:0] h_eff;

  always_comb begin
    if (img_w_q < IMG_W_W'(MIN_SIZE)) begin
      w_eff = CW1'(MIN_SIZE);
    end else if (int'(img_w_q) > int'(MAX_WIDTH)) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(img_w_q);
    end
    if (img_h_q < IMG_H_W'(MIN_SIZE)) begin
      h_eff = IMG_H_W'(MIN_SIZE);
    end else if (img_h_q > IMG_H_W'(HEIGHT_LIMIT)) begin
      h_eff = IMG_H_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = img_h_q;
    end
  end

  // ------------------------------------------------------------------
  // Pipeline valids and result queue occupancy
  // ------------------------------------------------------------------
  logic             v1_q, v2_q;
  logic [OQ_CW-1:0] oq_cnt_q;
  logic             in_acc;

  // Credit check: every in-flight request may still land in the queue.
  assign s_axis_tready = (oq_cnt_q + OQ_CW'(v1_q) + OQ_CW'(v2_q)) < OQ_CW'(OQ_DEPTH);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ------------------------------------------------------------------
  // Stage 0: position counters, line buffer read issue
  // ------------------------------------------------------------------
  logic [CW-1:0]      col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [CW-1:0]      c0;
  logic [ROW_W-1:0]   r0;
  logic [CW-1:0]      col_pre;
  logic [IMG_H_W-1:0] row_pre, row_adv;
  logic [CW1-1:0]     c_inc;
  logic [IMG_H_W-1:0] r_inc;
  logic [CW-1:0]      c0_m1;
  logic [ROW_W-1:0]   r0_m1;
  logic               emit0, last0;

  always_comb begin
    // frame start restarts at the origin
    col_pre = s_axis_tuser ? '0 : col_q;
    row_pre = s_axis_tuser ? '0 : {1'b0, row_q};
    // width shrank under a row in progress: start the next row
    if ({1'b0, col_pre} >= w_eff) begin
      c0      = '0;
      row_adv = row_pre + IMG_H_W'(1);
    end else begin
      c0      = col_pre;
      row_adv = row_pre;
    end
    r0 = (row_adv >= h_eff) ? '0 : row_adv[ROW_W-1:0];

    // position after this pixel
    c_inc = {1'b0, c0} + CW1'(1);
    r_inc = {1'b0, r0} + IMG_H_W'(1);
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_d = c_inc[CW-1:0];
      row_d = r0;
    end

    emit0 = (c0 >= CW'(2)) && (r0 >= ROW_W'(2));
    last0 = ({1'b0, c0} == (w_eff - CW1'(1))) && ({1'b0, r0} == (h_eff - IMG_H_W'(1)));
    c0_m1 = c0 - CW'(1);
    r0_m1 = r0 - ROW_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ------------------------------------------------------------------
  // Line buffer memory: entry = {row r-2, row r-1} at one column
  // ------------------------------------------------------------------
  logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] lb_rdata_q;
  logic [2*PIX_W-1:0] lb_wdata;
  logic               lb_we;
  logic [CW-1:0]      s1_c_q;

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      lb_mem[s1_c_q] <= lb_wdata;
    end
    if (in_acc) begin
      lb_rdata_q <= lb_mem[c0];
    end
  end

  // Same-column read and write in one cycle: forward the write data.
  logic               fwd_q;
  logic [2*PIX_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= in_acc && lb_we && (c0 == s1_c_q);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= lb_wdata;
  end

  // Stage 1 payload
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_emit_q, s1_last_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_c_q    <= c0;
      s1_pix_q  <= s_axis_tdata[PIX_W-1:0];
      s1_emit_q <= emit0;
      s1_last_q <= last0;
      s1_col_q  <= COL_W'(c0_m1);
      s1_row_q  <= r0_m1;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: write back, window shift, Laplacian and central differences
  // ------------------------------------------------------------------
  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0]   top_px, mid_px;
  logic [PIX_W-1:0]   win_q [9];
  logic [PIX_W-1:0]   win_n [9];
  logic [PIX_W-1:0]   nb_sum, lap1;
  logic signed [PIX_W:0] gx1, gy1;

  always_comb begin
    rd_data  = fwd_q ? fwd_data_q : lb_rdata_q;
    top_px   = rd_data[2*PIX_W-1:PIX_W];
    mid_px   = rd_data[PIX_W-1:0];
    lb_we    = v1_q;
    lb_wdata = {mid_px, s1_pix_q};

    for (int k = 0; k < 3; k++) begin
      win_n[k*3+0] = win_q[k*3+1];
      win_n[k*3+1] = win_q[k*3+2];
    end
    win_n[2] = top_px;
    win_n[5] = mid_px;
    win_n[8] = s1_pix_q;

    // wraps modulo 256 like the 8-bit result
    nb_sum = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        nb_sum = nb_sum + win_n[k];
      end
    end
    lap1 = {win_n[4][PIX_W-4:0], 3'b000} - nb_sum;
    gx1  = $signed({1'b0, win_n[5]}) - $signed({1'b0, win_n[3]});
    gy1  = $signed({1'b0, win_n[1]}) - $signed({1'b0, win_n[7]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (v1_q) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_n[k];
      end
    end
  end

  // Stage 2 payload
  logic [PIX_W-1:0]      s2_lap_q;
  logic signed [PIX_W:0] s2_gx_q, s2_gy_q;
  logic                  s2_emit_q, s2_last_q;
  logic [COL_W-1:0]      s2_col_q;
  logic [ROW_W-1:0]      s2_row_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      s2_lap_q  <= lap1;
      s2_gx_q   <= gx1;
      s2_gy_q   <= gy1;
      s2_emit_q <= s1_emit_q;
      s2_last_q <= s1_last_q;
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: squared gradient, both threshold tests
  // ------------------------------------------------------------------
  logic signed [2*PIX_W+1:0] gx_sq, gy_sq;
  logic [GRD_THR_W:0]        g2;
  logic                      white2;
  logic                      oq_push, oq_pop;
  out_item_t                 push_item;

  always_comb begin
    gx_sq  = s2_gx_q * s2_gx_q;
    gy_sq  = s2_gy_q * s2_gy_q;
    g2     = (GRD_THR_W+1)'($unsigned(gx_sq)) + (GRD_THR_W+1)'($unsigned(gy_sq));
    white2 = (s2_lap_q >= lap_thr_q) && (g2 >= {1'b0, grd_thr_q});

    push_item.last  = s2_last_q;
    push_item.white = white2;
    push_item.row   = s2_row_q;
    push_item.col   = s2_col_q;
    oq_push         = v2_q && s2_emit_q;
  end

  // ------------------------------------------------------------------
  // Result queue
  // ------------------------------------------------------------------
  out_item_t        oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_q, oq_rp_q;
  out_item_t        head;

  assign head          = oq_mem[oq_rp_q];
  assign m_axis_tvalid = (oq_cnt_q != '0);
  assign oq_pop        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {1'b0, head.white, head.row, head.col};
  assign m_axis_tlast  = head.last;

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem[oq_wp_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_q <= oq_wp_q + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rp_q <= oq_rp_q + OQ_AW'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_oq_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oq_push && !oq_pop) |-> (oq_cnt_q < OQ_CW'(OQ_DEPTH)))
    else $error("result queue overflow");

  a_s1_from_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $past(in_acc))
    else $error("stage 1 valid without accepted request");

  a_s2_from_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("stage 2 valid without stage 1");

  a_fwd_needs_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> ($past(v1_q) && $past(in_acc) && v1_q))
    else $error("forward without overlapping write-back");

endmodule

`default_nettype wire
